// ----- rtl/scbp_pkg.sv -----
// shared codes, widths and reset values of the size class buffer pool
`default_nettype none

package scbp_pkg;

    // field widths fixed by the item format
    localparam int CLASS_W  = 3;
    localparam int STATUS_W = 3;
    localparam int CAP_W    = 11;

    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CLASS_W-1:0]  class_t;
    typedef logic [CAP_W-1:0]    cap_t;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam status_t ST_FROM_CLASS  = 3'd0;
    localparam status_t ST_FRESH       = 3'd1;
    localparam status_t ST_BAD_CLASS   = 3'd2;
    localparam status_t ST_EXHAUSTED   = 3'd3;
    localparam status_t ST_FREED_CLASS = 3'd4;
    localparam status_t ST_FREED_SPARE = 3'd5;

    // cap registers, one per class that has one
    localparam int CAP_REGS  = 7;
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cap_t CAP_RESET [CAP_REGS] = '{
        11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd500
    };

endpackage

`default_nettype wire

// ----- rtl/size_class_buffer_pool.sv -----
// size class buffer pool: segregated free lists of buffer handles
//
// request channel (req_valid / req_stall): one item carries command,
// size_class and handle_in; an allocate pops a handle of the class, or a fresh
// one; a free returns handle_in to its class list or to the shared spare list
// response channel (rsp_valid / rsp_stall): one item per request with
// handle_out and status
// config channel (cfg_valid / cfg_ready): writes the per-class caps,
// always ready, indexes past the last cap are dropped
// timing: the link and tag memories are read at the accepting edge; a later
// edge, once the response register is free, updates the lists and loads the
// response register; no new request is taken until the last one is through,
// as a head cannot move before the link read for it is done;
// the response register parts the two sides: a new request is taken while a
// response still waits; if the receiver stalls, the following item waits in
// its update step with req_stall high until the response register is free
// reset: all lists empty, counts zero, no handle issued yet, caps at reset
// values; no memory clearing pass
`default_nettype none

module size_class_buffer_pool #(
    parameter int HANDLE_COUNT = 1024,
    parameter int CLASS_COUNT  = 7,
    localparam int HandleW     = $clog2(HANDLE_COUNT)
) (
    input  wire                     clk,
    input  wire                     rst_n,
    // request channel
    input  wire                     req_valid,
    output logic                    req_stall,
    input  wire                     command,
    input  wire  scbp_pkg::class_t  size_class,
    input  wire  [HandleW-1:0]      handle_in,
    // response channel
    output logic                    rsp_valid,
    input  wire                     rsp_stall,
    output logic [HandleW-1:0]      handle_out,
    output scbp_pkg::status_t       status,
    // config channel
    input  wire                     cfg_valid,
    output logic                    cfg_ready,
    input  wire  scbp_pkg::cfg_idx_t cfg_index,
    input  wire  scbp_pkg::cap_t    cfg_data
);

    import scbp_pkg::*;

    // list pointers carry one extra bit so the empty mark fits
    localparam int PtrW   = HandleW + 1;
    localparam int ClassW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam logic [PtrW-1:0] EmptyPtr = PtrW'(HANDLE_COUNT);

    // sequencer codes
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;

    // captured request
    logic            cmd_reg;
    class_t          cls_reg;
    logic [HandleW-1:0] hin_reg;

    // list heads, counts and caps
    logic [PtrW-1:0] head_reg  [CLASS_COUNT];
    logic [PtrW-1:0] head_next [CLASS_COUNT];
    cap_t            count_reg [CLASS_COUNT];
    cap_t            count_next[CLASS_COUNT];
    logic [PtrW-1:0] spare_reg, spare_next;
    logic [PtrW-1:0] unused_reg, unused_next;
    cap_t            cap_reg [CAP_REGS];

    // response register
    logic               rsp_valid_reg, rsp_valid_next;
    logic [HandleW-1:0] rsp_handle_reg, rsp_handle_next;
    status_t            rsp_status_reg, rsp_status_next;

    // memories: next link of each handle, class tag of each issued handle
    logic [PtrW-1:0] link_mem [HANDLE_COUNT];
    class_t          tag_mem  [HANDLE_COUNT];
    logic [PtrW-1:0] link_rd_reg;
    class_t          tag_rd_reg;

    logic               accept;
    logic               commit;
    logic [HandleW-1:0] link_raddr;

    logic               link_we;
    logic [HandleW-1:0] link_waddr;
    logic [PtrW-1:0]    link_wdata;
    logic               tag_we;
    logic [HandleW-1:0] tag_waddr;

    // accept side
    logic [ClassW+CLASS_W-1:0] acc_wide;
    logic [ClassW-1:0]         acc_idx;
    logic                      acc_ok;
    logic [PtrW-1:0]           acc_head;

    // update side
    logic [ClassW+CLASS_W-1:0] cls_wide;
    logic [ClassW-1:0]         cls_idx;
    logic                      cls_ok;
    logic [PtrW-1:0]           cur_head;
    logic [ClassW+CLASS_W-1:0] tag_wide;
    logic [ClassW-1:0]         tag_idx;
    logic                      tag_ok;
    cap_t                      tag_count;
    cap_t                      tag_cap;
    logic [PtrW-1:0]           hin_ptr;

    // one request in flight; accept only while idle
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign commit    = (state_reg == S_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign cfg_ready = 1'b1;

    assign rsp_valid  = rsp_valid_reg;
    assign handle_out = rsp_handle_reg;
    assign status     = rsp_status_reg;

    // pick the link to prefetch: class head, or spare head when class is empty
    always_comb
    begin
        acc_wide   = {{ClassW{1'b0}}, size_class};
        acc_idx    = acc_wide[ClassW-1:0];
        acc_ok     = (32'(size_class) < CLASS_COUNT);
        acc_head   = acc_ok ? head_reg[acc_idx] : EmptyPtr;
        link_raddr = (acc_head < EmptyPtr) ? acc_head[HandleW-1:0]
                                           : spare_reg[HandleW-1:0];
    end

    // list update on the prefetched link and tag
    always_comb
    begin
        cls_wide  = {{ClassW{1'b0}}, cls_reg};
        cls_idx   = cls_wide[ClassW-1:0];
        cls_ok    = (32'(cls_reg) < CLASS_COUNT);
        cur_head  = cls_ok ? head_reg[cls_idx] : EmptyPtr;
        tag_wide  = {{ClassW{1'b0}}, tag_rd_reg};
        tag_idx   = tag_wide[ClassW-1:0];
        tag_ok    = (32'(tag_rd_reg) < CLASS_COUNT);
        tag_count = tag_ok ? count_reg[tag_idx] : '0;
        tag_cap   = (32'(tag_rd_reg) < CAP_REGS) ? cap_reg[tag_rd_reg] : '0;
        hin_ptr   = {1'b0, hin_reg};

        head_next       = head_reg;
        count_next      = count_reg;
        spare_next      = spare_reg;
        unused_next     = unused_reg;
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_handle_next = rsp_handle_reg;
        rsp_status_next = rsp_status_reg;
        link_we         = 1'b0;
        link_waddr      = hin_reg;
        link_wdata      = spare_reg;
        tag_we          = 1'b0;
        tag_waddr       = unused_reg[HandleW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        if (!cls_ok)
                        begin
                            rsp_handle_next = '0;
                            rsp_status_next = ST_BAD_CLASS;
                        end
                        else if (cur_head < EmptyPtr)
                        begin
                            // pop the class list
                            head_next[cls_idx] = link_rd_reg;
                            if (count_reg[cls_idx] != '0)
                            begin
                                count_next[cls_idx] = count_reg[cls_idx] - 1'b1;
                            end
                            rsp_handle_next = cur_head[HandleW-1:0];
                            rsp_status_next = ST_FROM_CLASS;
                        end
                        else if (unused_reg < EmptyPtr)
                        begin
                            // never-used handle comes before the spare list
                            unused_next     = unused_reg + 1'b1;
                            tag_we          = 1'b1;
                            tag_waddr       = unused_reg[HandleW-1:0];
                            rsp_handle_next = unused_reg[HandleW-1:0];
                            rsp_status_next = ST_FRESH;
                        end
                        else if (spare_reg < EmptyPtr)
                        begin
                            spare_next      = link_rd_reg;
                            tag_we          = 1'b1;
                            tag_waddr       = spare_reg[HandleW-1:0];
                            rsp_handle_next = spare_reg[HandleW-1:0];
                            rsp_status_next = ST_FRESH;
                        end
                        else
                        begin
                            rsp_handle_next = '0;
                            rsp_status_next = ST_EXHAUSTED;
                        end
                    end
                    else
                    begin
                        rsp_handle_next = hin_reg;
                        if (hin_ptr >= EmptyPtr)
                        begin
                            // handle beyond the pool is dropped
                            rsp_status_next = ST_FREED_SPARE;
                        end
                        else if (tag_ok && (tag_count < tag_cap))
                        begin
                            link_we             = 1'b1;
                            link_wdata          = head_reg[tag_idx];
                            head_next[tag_idx]  = hin_ptr;
                            count_next[tag_idx] = tag_count + 1'b1;
                            rsp_status_next     = ST_FREED_CLASS;
                        end
                        else
                        begin
                            link_we         = 1'b1;
                            link_wdata      = spare_reg;
                            spare_next      = hin_ptr;
                            rsp_status_next = ST_FREED_SPARE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            spare_reg     <= EmptyPtr;
            unused_reg    <= '0;
            for (int i = 0; i < CLASS_COUNT; i++)
            begin
                head_reg[i]  <= EmptyPtr;
                count_reg[i] <= '0;
            end
            for (int i = 0; i < CAP_REGS; i++)
            begin
                cap_reg[i] <= CAP_RESET[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            spare_reg     <= spare_next;
            unused_reg    <= unused_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            if (cfg_valid && cfg_ready && (32'(cfg_index) < CAP_REGS))
            begin
                cap_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            cls_reg <= size_class;
            hin_reg <= handle_in;
        end
        rsp_handle_reg <= rsp_handle_next;
        rsp_status_reg <= rsp_status_next;
    end

    // link memory: read on accept, write on commit; never in the same cycle
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (accept)
        begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    // class tag memory
    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= cls_reg;
        end
        if (accept)
        begin
            tag_rd_reg <= tag_mem[handle_in];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/scbp_checker.sv -----
// port-level checks of the size class buffer pool
`default_nettype none

module scbp_checker #(
    parameter int HANDLE_COUNT = 1024,
    localparam int HandleW     = $clog2(HANDLE_COUNT)
) (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    req_valid,
    input wire                    req_stall,
    input wire                    rsp_valid,
    input wire                    rsp_stall,
    input wire [HandleW-1:0]      handle_out,
    input wire scbp_pkg::status_t status
);

    import scbp_pkg::*;

    // one request at a time: an accepted item blocks the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request accepted on back-to-back cycles");

    // a stalled response stays up
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> rsp_valid)
        else $error("response dropped while stalled");

    // status codes stay in range
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status <= ST_FREED_SPARE))
        else $error("undefined status code");

    // failed allocates grant no handle
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && ((status == ST_BAD_CLASS) || (status == ST_EXHAUSTED)))
            |-> (handle_out == '0))
        else $error("failed allocate carries a handle");

endmodule

bind size_class_buffer_pool scbp_checker #(
    .HANDLE_COUNT(HANDLE_COUNT)
) u_scbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .handle_out (handle_out),
    .status     (status)
);

`default_nettype wire
